// File: design/eft_pkg.sv
// Shared constants, types and codes for the event flag table.
package eft_pkg;

	localparam int NUM_SLOTS = 1024;
	localparam int ID_W = 10;
	localparam int PAT_W = 64;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int ROW_W = 64;
	localparam int BIT_W = $clog2(ROW_W);
	localparam int NUM_ROWS = (NUM_SLOTS + ROW_W - 1) / ROW_W;
	localparam int ROW_IDX_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int MAP_W = ROW_IDX_W + BIT_W;

	typedef enum logic [2:0] {
		ACT_CREATE = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_SET    = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_POLL   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_BUSY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOOK,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [2:0]       action;
		logic [ID_W-1:0]  flag_id;
		logic [PAT_W-1:0] bit_pattern;
		logic             match_any;
		logic             clear_all_on_match;
		logic             clear_mask_on_match;
	} req_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  new_id;
		logic [PAT_W-1:0] result_pattern;
	} rsp_item_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ROW_IDX_W-1:0] rd_row;
		logic                 wr_en;
		logic [ROW_IDX_W-1:0] wr_row;
		logic [ROW_W-1:0]     wr_word;
	} map_req_t;

	typedef struct packed {
		logic [ROW_IDX_W-1:0] free_row;
		logic                 has_free;
		logic [ROW_W-1:0]     row_word;
	} map_rsp_t;

endpackage

// File: design/eft_in_if.sv
// Request channel carrying one action item.
interface eft_in_if;
	import eft_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// File: design/eft_out_if.sv
// Response channel carrying one result item.
interface eft_out_if;
	import eft_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// File: design/event_flag_table.sv
// Event flag table top level: action sequencer, pattern memory and result register.
//
//   channel  dir  payload                                       handshake
//   req      in   action, flag_id, bit_pattern, poll controls   valid/ready
//   rsp      out  status, new_id, result_pattern                valid/ready
//
// Each item passes through accept, memory read, lookup and modify, and write back.
// The steps serve the pattern and valid-map read-modify-write; items never overlap.
// Reset clears the per-row valid and full flags of the map at once; no clearing pass.
// Write back holds while the result register is still held by the sink.
module event_flag_table (
	input  logic    clk,
	input  logic    arst_n,
	eft_in_if.sink    req,
	eft_out_if.source rsp
);
	import eft_pkg::*;

	state_t               state_q;
	state_t               state_d;
	req_item_t            req_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic                 full_q;
	logic [PAT_W-1:0]     pat_q;
	logic [PAT_W-1:0]     pmem [NUM_SLOTS];

	status_t              status_q;
	logic [ID_W-1:0]      new_id_q;
	logic [PAT_W-1:0]     result_q;
	logic                 vwr_q;
	logic [ROW_W-1:0]     vword_q;
	logic                 pwr_q;
	logic [SLOT_W-1:0]    paddr_q;
	logic [PAT_W-1:0]     pdata_q;

	status_t              l_status;
	logic [ID_W-1:0]      l_new_id;
	logic [PAT_W-1:0]     l_result;
	logic                 l_vwr;
	logic [ROW_W-1:0]     l_vword;
	logic                 l_pwr;
	logic [SLOT_W-1:0]    l_paddr;
	logic [PAT_W-1:0]     l_pdata;

	logic                 rsp_valid_q;
	rsp_item_t            rsp_item_q;

	map_req_t             mreq;
	map_rsp_t             mrsp;

	logic                 out_free;
	logic                 rd_en;
	logic                 wb;
	logic [ROW_W-1:0]     eff;
	logic [BIT_W-1:0]     id_bit;
	logic [ROW_W-1:0]     id_onehot;
	logic                 usable;
	logic [BIT_W-1:0]     zbit;
	logic [MAP_W-1:0]     new_slot;
	logic [PAT_W-1:0]     masked;
	logic                 hit;

	function automatic logic [BIT_W-1:0] lowest_zero(input logic [ROW_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (!w[b]) begin
				idx = BIT_W'(b);
			end
		end
		return idx;
	endfunction

	eft_vmap u_vmap (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.mrsp   (mrsp)
	);

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rd_en     = (state_q == ST_READ);
		wb        = (state_q == ST_WRITE) && out_free;
	end

	assign mreq.rd_en   = rd_en;
	assign mreq.rd_row  = (req_q.action == ACT_CREATE) ? mrsp.free_row
	                                                   : ROW_IDX_W'(req_q.flag_id >> BIT_W);
	assign mreq.wr_en   = wb && vwr_q;
	assign mreq.wr_row  = row_q;
	assign mreq.wr_word = vword_q;

	assign eff       = mrsp.row_word;
	assign id_bit    = req_q.flag_id[BIT_W-1:0];
	assign id_onehot = ROW_W'(1) << id_bit;
	assign usable    = (req_q.flag_id != '0) && (32'(req_q.flag_id) < 32'(NUM_SLOTS))
	                   && eff[id_bit];
	assign zbit      = lowest_zero(eff);
	assign new_slot  = {row_q, zbit};
	assign masked    = pat_q & req_q.bit_pattern;
	assign hit       = req_q.match_any ? (masked != '0) : (masked == req_q.bit_pattern);

	always_comb begin
		l_status = STAT_INVALID;
		l_new_id = '0;
		l_result = '0;
		l_vwr    = 1'b0;
		l_vword  = eff;
		l_pwr    = 1'b0;
		l_paddr  = SLOT_W'(req_q.flag_id);
		l_pdata  = pat_q;
		case (req_q.action)
			ACT_CREATE: begin
				if (full_q) begin
					l_status = STAT_FULL;
				end else begin
					l_status = STAT_OK;
					l_new_id = ID_W'(new_slot);
					l_vwr    = 1'b1;
					l_vword  = eff | (ROW_W'(1) << zbit);
					l_pwr    = 1'b1;
					l_paddr  = SLOT_W'(new_slot);
					l_pdata  = req_q.bit_pattern;
				end
			end
			ACT_DELETE: begin
				if (usable) begin
					l_status = STAT_OK;
					l_vwr    = 1'b1;
					l_vword  = eff & ~id_onehot;
				end
			end
			ACT_SET: begin
				if (usable) begin
					l_status = STAT_OK;
					l_pwr    = 1'b1;
					l_pdata  = pat_q | req_q.bit_pattern;
				end
			end
			ACT_CLEAR: begin
				if (usable) begin
					l_status = STAT_OK;
					l_pwr    = 1'b1;
					l_pdata  = masked;
				end
			end
			ACT_POLL: begin
				if (usable) begin
					if (hit) begin
						l_status = STAT_OK;
						l_result = pat_q;
						if (req_q.clear_all_on_match) begin
							l_pwr   = 1'b1;
							l_pdata = '0;
						end else if (req_q.clear_mask_on_match) begin
							l_pwr   = 1'b1;
							l_pdata = pat_q & ~req_q.bit_pattern;
						end
					end else begin
						l_status = STAT_BUSY;
					end
				end
			end
			default: begin
				l_status = STAT_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wb) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.item;
		end
		if (rd_en) begin
			row_q  <= mreq.rd_row;
			full_q <= !mrsp.has_free;
			pat_q  <= pmem[SLOT_W'(req_q.flag_id)];
		end
		if (state_q == ST_LOOK) begin
			status_q <= l_status;
			new_id_q <= l_new_id;
			result_q <= l_result;
			vwr_q    <= l_vwr;
			vword_q  <= l_vword;
			pwr_q    <= l_pwr;
			paddr_q  <= l_paddr;
			pdata_q  <= l_pdata;
		end
		if (wb) begin
			if (pwr_q) begin
				pmem[paddr_q] <= pdata_q;
			end
			rsp_item_q.status         <= status_q;
			rsp_item_q.new_id         <= new_id_q;
			rsp_item_q.result_pattern <= result_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_item_q;

	a_id_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.item.new_id != '0) |-> rsp.item.status == STAT_OK)
		else $error("new_id given without ok status");

	a_quiet_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.item.status != STAT_OK) |->
		(rsp.item.result_pattern == '0) && (rsp.item.new_id == '0))
		else $error("error result carries id or pattern");

	a_result_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_WRITE)
		else $error("result raised outside write back");

	a_map_write_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.wr_en |-> (state_q == ST_WRITE) && !req.ready)
		else $error("map written outside write back");
endmodule

// File: design/eft_vmap.sv
// Slot occupancy map: one row memory of valid bits with per-row valid and full flags.
module eft_vmap (
	input  logic              clk,
	input  logic              arst_n,
	input  eft_pkg::map_req_t mreq,
	output eft_pkg::map_rsp_t mrsp
);
	import eft_pkg::*;

	logic [ROW_W-1:0]    vmem [NUM_ROWS];
	logic [NUM_ROWS-1:0] row_vld_q;
	logic [NUM_ROWS-1:0] row_full_q;
	logic [ROW_W-1:0]    word_q;
	logic [ROW_W-1:0]    fixed_q;
	logic                hit_vld_q;

	function automatic logic [ROW_W-1:0] fixed_mask(input logic [ROW_IDX_W-1:0] row);
		logic [ROW_W-1:0] m;
		int unsigned      slot;
		for (int b = 0; b < ROW_W; b++) begin
			slot = int'(row) * ROW_W + b;
			m[b] = (slot == 0) || (slot >= NUM_SLOTS);
		end
		return m;
	endfunction

	always_comb begin
		mrsp.free_row = '0;
		mrsp.has_free = 1'b0;
		mrsp.row_word = (hit_vld_q ? word_q : '0) | fixed_q;
		for (int r = NUM_ROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				mrsp.free_row = ROW_IDX_W'(r);
				mrsp.has_free = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			row_full_q <= '0;
		end else if (mreq.wr_en) begin
			row_vld_q[mreq.wr_row]  <= 1'b1;
			row_full_q[mreq.wr_row] <= &mreq.wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			vmem[mreq.wr_row] <= mreq.wr_word;
		end
		if (mreq.rd_en) begin
			word_q    <= vmem[mreq.rd_row];
			fixed_q   <= fixed_mask(mreq.rd_row);
			hit_vld_q <= row_vld_q[mreq.rd_row];
		end
	end
endmodule

// File: verif/tb_event_flag_table.sv
// Testbench for the event flag table: directed and random actions checked against a local predictor.
module tb_event_flag_table;
	import eft_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 8;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int FULL_TARGET = 30;
	localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ACT_RSVD_MID = 3'd6;
	localparam logic [2:0] ACT_RSVD_LAST = 3'd7;
	localparam logic [PAT_W-1:0] PAT_ZERO = '0;
	localparam logic [PAT_W-1:0] PAT_ONES = '1;

	logic clk;
	logic arst_n;

	eft_in_if  req_ch();
	eft_out_if rsp_ch();

	event_flag_table uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	bit               slot_used [NUM_SLOTS];
	bit [PAT_W-1:0]   flag_bits [NUM_SLOTS];
	int               live_slots;
	int               full_seen;
	rsp_item_t        owed_replies[$];
	rsp_item_t        want;
	int               fail_count;
	int               quiet_cycles;
	bit               req_idle_en;
	bit               rsp_idle_en;
	bit               rsp_hold_req;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic rsp_item_t apply_action(input req_item_t rq);
		rsp_item_t        rs;
		logic [PAT_W-1:0] cur;
		logic             hit;
		bit               found;
		rs = '0;
		rs.status = STAT_INVALID;
		if (rq.action == ACT_CREATE) begin
			rs.status = STAT_FULL;
			found = 1'b0;
			for (int s = 1; s < NUM_SLOTS; s++) begin
				if (!found && !slot_used[s]) begin
					found = 1'b1;
					slot_used[s] = 1'b1;
					flag_bits[s] = rq.bit_pattern;
					live_slots++;
					rs.new_id = ID_W'(s);
					rs.status = STAT_OK;
				end
			end
			if (!found)
				full_seen++;
		end else if (rq.action <= ACT_POLL && rq.flag_id != 0 && rq.flag_id < NUM_SLOTS
				&& slot_used[rq.flag_id]) begin
			cur = flag_bits[rq.flag_id];
			rs.status = STAT_OK;
			case (rq.action)
				ACT_DELETE: begin
					slot_used[rq.flag_id] = 1'b0;
					live_slots--;
				end
				ACT_SET: flag_bits[rq.flag_id] = cur | rq.bit_pattern;
				ACT_CLEAR: flag_bits[rq.flag_id] = cur & rq.bit_pattern;
				default: begin
					if (rq.match_any)
						hit = (cur & rq.bit_pattern) != PAT_ZERO;
					else
						hit = (cur & rq.bit_pattern) == rq.bit_pattern;
					if (hit) begin
						rs.result_pattern = cur;
						if (rq.clear_all_on_match)
							flag_bits[rq.flag_id] = PAT_ZERO;
						else if (rq.clear_mask_on_match)
							flag_bits[rq.flag_id] = cur & ~rq.bit_pattern;
					end else begin
						rs.status = STAT_BUSY;
					end
				end
			endcase
		end
		return rs;
	endfunction

	function automatic req_item_t pack_req(input logic [2:0] act, input logic [ID_W-1:0] id,
			input logic [PAT_W-1:0] pat, input logic any, input logic clr_all,
			input logic clr_mask);
		req_item_t rq;
		rq.action = act;
		rq.flag_id = id;
		rq.bit_pattern = pat;
		rq.match_any = any;
		rq.clear_all_on_match = clr_all;
		rq.clear_mask_on_match = clr_mask;
		return rq;
	endfunction

	function automatic logic [PAT_W-1:0] random_pattern();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		int unsigned start;
		int unsigned s;
		if (live_slots == 0 || $urandom_range(0, 9) < 2)
			return ID_W'($urandom_range(0, (1 << ID_W) - 1));
		start = $urandom_range(1, NUM_SLOTS - 1);
		for (int k = 0; k < NUM_SLOTS; k++) begin
			s = (start + k) % NUM_SLOTS;
			if (slot_used[s])
				return ID_W'(s);
		end
		return '0;
	endfunction

	function automatic req_item_t random_req(input int unsigned create_pct);
		req_item_t        rq;
		int unsigned      roll;
		logic [PAT_W-1:0] cur;
		roll = $urandom_range(0, 99);
		rq = pack_req(ACT_CREATE, pick_id(), PAT_ZERO, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if (roll < create_pct) begin
			rq.action = ACT_CREATE;
		end else if (roll < create_pct + 2) begin
			rq.action = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
		end else begin
			case ($urandom_range(0, 9))
				0:       rq.action = ACT_DELETE;
				1, 2:    rq.action = ACT_SET;
				3, 4:    rq.action = ACT_CLEAR;
				default: rq.action = ACT_POLL;
			endcase
		end
		cur = (rq.flag_id < NUM_SLOTS && slot_used[rq.flag_id]) ? flag_bits[rq.flag_id]
			: random_pattern();
		case ($urandom_range(0, 7))
			0:       rq.bit_pattern = PAT_ZERO;
			1:       rq.bit_pattern = PAT_ONES;
			2, 3:    rq.bit_pattern = cur & random_pattern();
			4:       rq.bit_pattern = cur;
			default: rq.bit_pattern = random_pattern();
		endcase
		return rq;
	endfunction

	task automatic send_req(input req_item_t rq);
		if (req_idle_en && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.item <= rq;
		do @(posedge clk); while (!req_ch.ready);
		owed_replies.push_back(apply_action(rq));
	endtask

	task automatic test_directed();
		send_req(pack_req(ACT_POLL, 0, PAT_ONES, 1'b1, 1'b1, 1'b1));
		send_req(pack_req(ACT_DELETE, 5, PAT_ZERO, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_CREATE, 0, PAT_ZERO, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_CREATE, 1023, PAT_ONES, 1'b1, 1'b1, 1'b1));
		send_req(pack_req(ACT_CREATE, 7, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_SET, 1, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_CLEAR, 2, 64'h0000_FFFF_0000_FFFF, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_POLL, 1, PAT_ZERO, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_POLL, 1, PAT_ZERO, 1'b1, 1'b0, 1'b0));
		send_req(pack_req(ACT_POLL, 2, PAT_ONES, 1'b0, 1'b0, 1'b1));
		send_req(pack_req(ACT_POLL, 2, 64'h0000_0000_0000_0001, 1'b1, 1'b0, 1'b1));
		send_req(pack_req(ACT_POLL, 2, PAT_ONES, 1'b1, 1'b0, 1'b0));
		send_req(pack_req(ACT_POLL, 3, 64'h8000_0000_0000_0001, 1'b0, 1'b1, 1'b1));
		send_req(pack_req(ACT_POLL, 3, PAT_ONES, 1'b1, 1'b0, 1'b0));
		send_req(pack_req(ACT_RSVD_FIRST, 1, PAT_ONES, 1'b1, 1'b1, 1'b1));
		send_req(pack_req(ACT_RSVD_MID, 1, PAT_ZERO, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_RSVD_LAST, 2, PAT_ONES, 1'b0, 1'b1, 1'b0));
		send_req(pack_req(ACT_DELETE, 2, PAT_ZERO, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_POLL, 2, PAT_ZERO, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_SET, 1023, PAT_ONES, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_CREATE, 0, 64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 1'b0));
		send_req(pack_req(ACT_POLL, 2, 64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 1'b1));
		send_req(pack_req(ACT_POLL, 2, 64'hDEAD_BEEF_0123_4567, 1'b1, 1'b0, 1'b0));
	endtask

	task automatic test_output_backpressure();
		rsp_hold_req = 1'b1;
		repeat (12) send_req(random_req(30));
		req_ch.valid <= 1'b0;
		wait (owed_replies.size() == 0);
	endtask

	task automatic test_random_mix();
		repeat (200) send_req(random_req(30));
	endtask

	task automatic test_table_fill();
		full_seen = 0;
		while (full_seen < FULL_TARGET)
			send_req(random_req(90));
	endtask

	task automatic test_unstalled_burst();
		repeat (100) send_req(random_req(20));
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				rsp_hold_req = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d id %0d pattern %h",
					$time, rsp_ch.item.status, rsp_ch.item.new_id, rsp_ch.item.result_pattern);
				fail_count++;
			end else begin
				want = owed_replies.pop_front();
				if (rsp_ch.item.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, rsp_ch.item.status);
					fail_count++;
				end
				if (rsp_ch.item.new_id !== want.new_id) begin
					$display("%0t: new_id mismatch: expected %0d, actual %0d",
						$time, want.new_id, rsp_ch.item.new_id);
					fail_count++;
				end
				if (rsp_ch.item.result_pattern !== want.result_pattern) begin
					$display("%0t: result_pattern mismatch: expected %h, actual %h",
						$time, want.result_pattern, rsp_ch.item.result_pattern);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL event_flag_table");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.item <= '0;
		fail_count = 0;
		quiet_cycles = 0;
		live_slots = 0;
		full_seen = 0;
		rsp_hold_req = 1'b0;
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_backpressure();
		test_random_mix();
		test_table_fill();
		req_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		test_unstalled_burst();
		req_ch.valid <= 1'b0;
		wait (owed_replies.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS event_flag_table");
		else
			$display("FAIL event_flag_table");
		$finish;
	end

endmodule
